FILE: rtl/core/ertp_pkg.sv
// Package for the Euler rigid point transform block.
// Holds default widths, register indexes, the sequencer state type and the
// CORDIC arctangent table. No dependencies.
package ertp_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int TERM_BITS_DEF  = 18;
  localparam int ANGLE_BITS     = 16;

  // CORDIC datapath: x and y in Q2.30 with headroom, angle in units of pi/2^31.
  localparam int CORDIC_ITERS = 28;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_ZW    = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  // Configuration register indexes.
  localparam logic [2:0] REG_ROLL  = 3'd0;
  localparam logic [2:0] REG_PITCH = 3'd1;
  localparam logic [2:0] REG_YAW   = 3'd2;
  localparam logic [2:0] REG_ORG_X = 3'd3;
  localparam logic [2:0] REG_ORG_Y = 3'd4;
  localparam logic [2:0] REG_ORG_Z = 3'd5;

  // Matrix rebuild sequencer.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_ROT,
    SEQ_FIN,
    SEQ_MAT1,
    SEQ_MAT2
  } seq_state_t;

endpackage

FILE: rtl/core/ertp_in_if.sv
// Input channel of the Euler rigid point transform: one point word per handshake.
// Depends on ertp_pkg for the default coordinate width.
interface ertp_in_if #(
  parameter int COORD_BITS = ertp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, op, point_x, point_y, point_z, input ready);
  modport sink   (input valid, op, point_x, point_y, point_z, output ready);
endinterface

FILE: rtl/core/ertp_out_if.sv
// Result channel of the Euler rigid point transform: one result word per handshake.
// Depends on ertp_pkg for the default coordinate width.
interface ertp_out_if #(
  parameter int COORD_BITS = ertp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] result_x;
  logic signed [COORD_BITS-1:0] result_y;
  logic signed [COORD_BITS-1:0] result_z;
  logic                         saturated;

  modport source (output valid, result_x, result_y, result_z, saturated, input ready);
  modport sink   (input valid, result_x, result_y, result_z, saturated, output ready);
endinterface

FILE: rtl/core/euler_rigid_point_transform_top.sv
// Euler ZYX rigid point transform. Takes one point word per cycle and returns one
// result word per cycle through three registers (input register, product
// register, result register); a stalled result stalls the whole pipe. Writing an
// angle register, and leaving reset, starts a rebuild of the rotation matrix:
// a CORDIC unit shared by the three angles handles each angle in turn (load,
// rotation, finish), then two steps form the matrix terms; in ready is low meanwhile.
// Depends on ertp_pkg, ertp_in_if and ertp_out_if.
module euler_rigid_point_transform_top #(
  parameter int COORD_BITS = ertp_pkg::COORD_BITS_DEF,
  parameter int TERM_BITS  = ertp_pkg::TERM_BITS_DEF,
  localparam int CFG_DATA_BITS = (COORD_BITS > 32) ? 64 : 32,
  localparam int CFG_ADDR_BITS = (COORD_BITS > 32) ? 6 : 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ertp_in_if.sink                  in_ch,
  ertp_out_if.source               out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);
  import ertp_pkg::*;

  localparam int F        = TERM_BITS - 2;
  localparam int ADDR_LSB = CFG_ADDR_BITS - 3;
  localparam int WT       = 2 * TERM_BITS + 1;
  localparam int VW       = COORD_BITS + 1;
  localparam int PW       = TERM_BITS + VW;
  localparam int SW       = PW + 2;
  localparam int RW       = SW - F;
  localparam int OW       = RW + 1;
  localparam int RSH      = 30 - F;

  localparam logic signed [WT-1:0] TERM_HALF = WT'(1) << (F - 1);
  localparam logic signed [WT-1:0] TERM_MAX  = WT'((1 << (TERM_BITS - 1)) - 1);
  localparam logic signed [WT-1:0] TERM_MIN  = -TERM_MAX - WT'(1);
  localparam logic signed [CORDIC_W-1:0] SC_HALF = CORDIC_W'(1) << (RSH - 1);
  localparam logic signed [CORDIC_W-1:0] SC_ONE  = CORDIC_W'(1) << F;
  localparam logic signed [SW-1:0] PT_HALF = SW'(1) << (F - 1);
  localparam logic signed [OW-1:0] COORD_MAX = OW'({1'b0, {(COORD_BITS - 1){1'b1}}});
  localparam logic signed [OW-1:0] COORD_MIN = -COORD_MAX - OW'(1);

  function automatic logic signed [TERM_BITS-1:0] term_clamp(
    input logic signed [WT-1:0] v
  );
    logic signed [WT-1:0] c;
    c = v;
    if (v > TERM_MAX) c = TERM_MAX;
    if (v < TERM_MIN) c = TERM_MIN;
    return TERM_BITS'(c);
  endfunction

  function automatic logic signed [TERM_BITS-1:0] term_round(
    input logic signed [WT-1:0] v
  );
    logic signed [WT-1:0] r;
    r = (v + TERM_HALF) >>> F;
    return term_clamp(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [ANGLE_BITS-1:0] ang_r [3];
  logic signed [COORD_BITS-1:0] org_r [3];
  logic [2:0] cfg_idx;
  logic       cfg_wr;
  logic       ang_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_BITS-1:ADDR_LSB];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign ang_wr     = cfg_wr && (cfg_idx == REG_ROLL || cfg_idx == REG_PITCH ||
                                 cfg_idx == REG_YAW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ang_r[i] <= '0;
        org_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROLL:  ang_r[0] <= cfg_pwdata[ANGLE_BITS-1:0];
        REG_PITCH: ang_r[1] <= cfg_pwdata[ANGLE_BITS-1:0];
        REG_YAW:   ang_r[2] <= cfg_pwdata[ANGLE_BITS-1:0];
        REG_ORG_X: org_r[0] <= cfg_pwdata[COORD_BITS-1:0];
        REG_ORG_Y: org_r[1] <= cfg_pwdata[COORD_BITS-1:0];
        REG_ORG_Z: org_r[2] <= cfg_pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROLL:  cfg_prdata = CFG_DATA_BITS'(ang_r[0]);
      REG_PITCH: cfg_prdata = CFG_DATA_BITS'(ang_r[1]);
      REG_YAW:   cfg_prdata = CFG_DATA_BITS'(ang_r[2]);
      REG_ORG_X: cfg_prdata = CFG_DATA_BITS'(org_r[0]);
      REG_ORG_Y: cfg_prdata = CFG_DATA_BITS'(org_r[1]);
      REG_ORG_Z: cfg_prdata = CFG_DATA_BITS'(org_r[2]);
      default:   cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Matrix rebuild sequencer: CORDIC per angle, then the matrix terms.
  // ---------------------------------------------------------------------------
  seq_state_t state_r, state_nxt;
  logic [1:0] asel_r;
  logic [4:0] iter_r;
  logic       neg_r;
  logic       seq_busy;
  logic signed [CORDIC_W-1:0]  cx_r, cy_r;
  logic signed [CORDIC_ZW-1:0] cz_r;
  logic signed [TERM_BITS-1:0] sin_r [3];
  logic signed [TERM_BITS-1:0] cos_r [3];
  logic signed [TERM_BITS-1:0] t1_r, t2_r;
  logic signed [TERM_BITS-1:0] rot_r [9];

  always_comb begin
    state_nxt = state_r;
    if (ang_wr) begin
      state_nxt = SEQ_LOAD;
    end else begin
      unique case (state_r)
        SEQ_IDLE: state_nxt = SEQ_IDLE;
        SEQ_LOAD: state_nxt = SEQ_ROT;
        SEQ_ROT:  if (iter_r == 5'(CORDIC_ITERS - 1)) state_nxt = SEQ_FIN;
        SEQ_FIN:  state_nxt = (asel_r == 2'd2) ? SEQ_MAT1 : SEQ_LOAD;
        SEQ_MAT1: state_nxt = SEQ_MAT2;
        SEQ_MAT2: state_nxt = SEQ_IDLE;
        default:  state_nxt = SEQ_IDLE;
      endcase
    end
  end

  always_comb begin
    seq_busy = (state_r != SEQ_IDLE);
  end

  // Angle folding into [-pi/2, pi/2]; the results of a folded angle are negated afterwards.
  logic signed [ANGLE_BITS:0]  a_ext, a_fold;
  logic                        fold_hi, fold_lo;
  logic signed [CORDIC_W-1:0]  xs, ys, xf, yf, xr, yr, xc, yc;
  logic signed [CORDIC_ZW-1:0] atan_v;

  always_comb begin
    a_ext   = (ANGLE_BITS + 1)'(ang_r[asel_r]);
    fold_hi = a_ext > 17'sd16384;
    fold_lo = a_ext < -17'sd16384;
    if (fold_hi) a_fold = a_ext - 17'sd32768;
    else if (fold_lo) a_fold = a_ext + 17'sd32768;
    else a_fold = a_ext;
    xs     = cx_r >>> iter_r;
    ys     = cy_r >>> iter_r;
    atan_v = $signed({1'b0, ATAN_TAB[iter_r]});
    xf     = neg_r ? -cx_r : cx_r;
    yf     = neg_r ? -cy_r : cy_r;
    xr     = (xf + SC_HALF) >>> RSH;
    yr     = (yf + SC_HALF) >>> RSH;
    xc     = (xr > SC_ONE) ? SC_ONE : ((xr < -SC_ONE) ? -SC_ONE : xr);
    yc     = (yr > SC_ONE) ? SC_ONE : ((yr < -SC_ONE) ? -SC_ONE : yr);
  end

  logic signed [WT-1:0] srw, crw, spw, cpw, syw, cyw, t1w, t2w;

  always_comb begin
    srw = WT'(sin_r[0]);
    crw = WT'(cos_r[0]);
    spw = WT'(sin_r[1]);
    cpw = WT'(cos_r[1]);
    syw = WT'(sin_r[2]);
    cyw = WT'(cos_r[2]);
    t1w = WT'(t1_r);
    t2w = WT'(t2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_LOAD;
      asel_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (ang_wr) asel_r <= 2'd0;
      else if (state_r == SEQ_FIN) asel_r <= asel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SEQ_LOAD: begin
        cx_r   <= CORDIC_X0;
        cy_r   <= '0;
        cz_r   <= {a_fold, 16'h0000};
        neg_r  <= fold_hi | fold_lo;
        iter_r <= 5'd0;
      end
      SEQ_ROT: begin
        if (!cz_r[CORDIC_ZW-1]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + atan_v;
        end
        iter_r <= iter_r + 5'd1;
      end
      SEQ_FIN: begin
        cos_r[asel_r] <= TERM_BITS'(xc);
        sin_r[asel_r] <= TERM_BITS'(yc);
      end
      SEQ_MAT1: begin
        t1_r     <= term_round(srw * spw);
        t2_r     <= term_round(crw * spw);
        rot_r[0] <= term_round(cpw * cyw);
        rot_r[1] <= term_round(cpw * syw);
        rot_r[2] <= term_clamp(-spw);
        rot_r[5] <= term_round(srw * cpw);
        rot_r[8] <= term_round(crw * cpw);
      end
      SEQ_MAT2: begin
        rot_r[3] <= term_round(t1w * cyw - crw * syw);
        rot_r[4] <= term_round(t1w * syw + crw * cyw);
        rot_r[6] <= term_round(t2w * cyw + srw * syw);
        rot_r[7] <= term_round(t2w * syw - srw * cyw);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Point pipeline: input register, product register, result register.
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic in_acc;
  logic signed [COORD_BITS-1:0] pt [3];

  logic                  s1_v_r, s1_op_r;
  logic signed [VW-1:0]  s1_vec_r [3];
  logic                  s2_v_r, s2_op_r;
  logic signed [PW-1:0]  prod_r [3][3];
  logic                  out_v_r, sat_r;
  logic signed [COORD_BITS-1:0] res_r [3];

  logic signed [SW-1:0]  sum_s [3];
  logic signed [OW-1:0]  coord_s [3];
  logic signed [COORD_BITS-1:0] res_s [3];
  logic [2:0]            clip_s;

  assign pipe_en     = !out_v_r || out_ch.ready;
  assign in_ch.ready = pipe_en && !seq_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pt[0]       = in_ch.point_x;
  assign pt[1]       = in_ch.point_y;
  assign pt[2]       = in_ch.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r  <= in_acc;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (in_acc) begin
        s1_op_r <= in_ch.op;
        for (int i = 0; i < 3; i++) begin
          s1_vec_r[i] <= in_ch.op ? VW'(pt[i]) : VW'(pt[i]) - VW'(org_r[i]);
        end
      end
      s2_op_r <= s1_op_r;
      // The local-to-parent direction uses the transposed matrix.
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= (s1_op_r ? PW'(rot_r[3 * j + i]) : PW'(rot_r[3 * i + j])) *
                          PW'(s1_vec_r[j]);
        end
      end
      if (s2_v_r) begin
        for (int i = 0; i < 3; i++) res_r[i] <= res_s[i];
        sat_r <= |clip_s;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_s[i] = (SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2]) + PT_HALF)
                 >>> F;
      coord_s[i] = s2_op_r ? OW'(RW'(sum_s[i])) + OW'(org_r[i]) : OW'(RW'(sum_s[i]));
      clip_s[i]  = (coord_s[i] > COORD_MAX) || (coord_s[i] < COORD_MIN);
      if (coord_s[i] > COORD_MAX) res_s[i] = COORD_BITS'(COORD_MAX);
      else if (coord_s[i] < COORD_MIN) res_s[i] = COORD_BITS'(COORD_MIN);
      else res_s[i] = COORD_BITS'(coord_s[i]);
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.result_x  = res_r[0];
  assign out_ch.result_y  = res_r[1];
  assign out_ch.result_z  = res_r[2];
  assign out_ch.saturated = sat_r;

`ifndef SYNTHESIS
  // An accepted word always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted word missing from input register");

  // A word in the product register moves to the result register when the pipe advances.
  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && s2_v_r |=> out_v_r)
    else $error("word lost between product and result registers");

  // An angle write always restarts the matrix rebuild from the first angle.
  a_rebuild_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ang_wr |=> (state_r == SEQ_LOAD) && (asel_r == 2'd0))
    else $error("angle write did not restart the matrix rebuild");

  // The CORDIC iteration count never runs past the table.
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_ROT) |-> (iter_r < 5'(CORDIC_ITERS)))
    else $error("CORDIC iteration count out of range");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the Euler rigid point transform block.
// Depends on ertp_pkg, ertp_in_if, ertp_out_if and euler_rigid_point_transform_top.
// Point words are checked against a fixed-point predictor kept in step with the APB writes.
`timescale 1ns / 100ps

module testbench;
  import ertp_pkg::*;

  localparam int  FRAC     = TERM_BITS_DEF - 2;
  localparam longint TERM_MAX = (longint'(1) << (TERM_BITS_DEF - 1)) - 1;
  localparam longint CRD_MAX  = 64'sd2147483647;
  localparam longint CRD_MIN  = -64'sd2147483648;
  localparam longint LIMIT    = 3000000;
  localparam int  RAND_PER_PHASE = 232;

  typedef struct packed {
    logic               op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } coord_t;

  typedef struct packed {
    point_t pt;
    logic   typed;
    coord_t res;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ertp_in_if  in_ch();
  ertp_out_if out_ch();

  euler_rigid_point_transform_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: angles, frame origin and the derived rotation matrix.
  longint angle_q[3];
  longint origin_q[3];
  longint rot_m[9];
  coord_t pending_results[$];
  int     errors = 0;
  int     words_in = 0, words_out = 0, sat_seen = 0;
  longint cycles = 0;
  bit     hold_req = 1'b0;
  bit     rx_quiet = 1'b0;

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void cordic_sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, z, xs, ys, one;
    bit flip;
    a = ang;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    one = longint'(1) << FRAC;
    // Fold into [-pi/2, pi/2]; the quadrant shift negates both results.
    if (a > 16384) begin
      a -= 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1'b1;
    end
    z = a * 65536;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(round_shift(x, 30 - FRAC), -one, one);
    s = clip(round_shift(y, 30 - FRAC), -one, one);
  endfunction

  function automatic void rebuild_rotation();
    longint sr, cr, sp, cp, sy, cy, t1, t2;
    cordic_sin_cos(angle_q[0], sr, cr);
    cordic_sin_cos(angle_q[1], sp, cp);
    cordic_sin_cos(angle_q[2], sy, cy);
    t1 = round_shift(sr * sp, FRAC);
    t2 = round_shift(cr * sp, FRAC);
    rot_m[0] = round_shift(cp * cy, FRAC);
    rot_m[1] = round_shift(cp * sy, FRAC);
    rot_m[2] = -sp;
    rot_m[3] = round_shift(t1 * cy - cr * sy, FRAC);
    rot_m[4] = round_shift(t1 * sy + cr * cy, FRAC);
    rot_m[5] = round_shift(sr * cp, FRAC);
    rot_m[6] = round_shift(t2 * cy + sr * sy, FRAC);
    rot_m[7] = round_shift(t2 * sy - sr * cy, FRAC);
    rot_m[8] = round_shift(cr * cp, FRAC);
    for (int i = 0; i < 9; i++) rot_m[i] = clip(rot_m[i], -TERM_MAX - 1, TERM_MAX);
  endfunction

  function automatic coord_t transform_point(point_t p);
    longint v[3], acc;
    coord_t r;
    longint o[3];
    v[0] = p.x;
    v[1] = p.y;
    v[2] = p.z;
    r.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!p.op) v[i] -= origin_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += (p.op ? rot_m[3 * j + i] : rot_m[3 * i + j]) * v[j];
      acc = round_shift(acc, FRAC);
      if (p.op) acc += origin_q[i];
      if (acc > CRD_MAX || acc < CRD_MIN) r.sat = 1'b1;
      o[i] = clip(acc, CRD_MIN, CRD_MAX);
    end
    r.x = o[0][31:0];
    r.y = o[1][31:0];
    r.z = o[2][31:0];
    return r;
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx <= REG_YAW) begin
      angle_q[idx] = longint'($signed(data[15:0]));
      rebuild_rotation();
    end else begin
      origin_q[idx - REG_ORG_X] = longint'($signed(data));
    end
  endtask

  // The sender holds valid across back-to-back words; this task only drops it for a gap.
  task automatic send_point(point_t p, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= p.op;
    in_ch.point_x <= p.x;
    in_ch.point_y <= p.y;
    in_ch.point_z <= p.z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_in++;
  endtask

  task automatic wait_drained();
    // The last word has just been taken, so valid must drop before waiting.
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // The queue is empty, so the three-stage pipe holds no words; a margin follows.
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_gap(bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy) return 0;
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: checks each result word and stalls at random (not while rx_quiet) or on hold_req.
  initial begin
    int stall_left;
    coord_t want, got;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.result_x, out_ch.result_y, out_ch.result_z, out_ch.saturated};
        words_out++;
        if (got.sat) sat_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (want.x !== got.x || want.y !== got.y || want.z !== got.z ||
              want.sat !== got.sat) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                     $time, want.x, want.y, want.z, want.sat,
                     got.x, got.y, got.z, got.sat);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 99) < 20)
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  // Accepted words are predicted here, at the edge where the handshake completes.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_results.push_back(transform_point('{in_ch.op, in_ch.point_x,
                                                  in_ch.point_y, in_ch.point_z}));
  end

  vector_t directed_tab[] = '{
    '{'{1'b0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
    '{'{1'b1, 32'sd65536, -32'sd65536, 32'sd3}, 1'b1,
      '{32'sd65536, -32'sd65536, 32'sd3, 1'b0}},
    '{'{1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b1,
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0}},
    '{'{1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b1,
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0}},
    '{'{1'b1, 32'sh7fffffff, 32'sh80000000, -32'sd1}, 1'b1,
      '{32'sh7fffffff, 32'sh80000000, -32'sd1, 1'b0}},
    '{'{1'b1, 32'sh80000000, 32'sh7fffffff, 32'sd1}, 1'b1,
      '{32'sh80000000, 32'sh7fffffff, 32'sd1, 1'b0}},
    '{'{1'b0, -32'sd1, 32'sd1, 32'sh55555555}, 1'b1,
      '{-32'sd1, 32'sd1, 32'sh55555555, 1'b0}},
    '{'{1'b1, 32'shaaaaaaaa, 32'sh0000ffff, 32'shffff0000}, 1'b0, '0},
    '{'{1'b0, 32'sh12345678, -32'sd98765, 32'sd32768}, 1'b0, '0},
    '{'{1'b1, 32'sd32767, -32'sd32769, 32'sh40000000}, 1'b0, '0}
  };

  // Phase settings: roll, pitch, yaw, origin x, y, z. Angles of -pi and the
  // widest origins are among them; the later rows are drawn at random.
  logic [31:0] phase_cfg[8][6];

  initial begin
    coord_t want;
    point_t p;
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    for (int i = 0; i < 3; i++) begin
      angle_q[i] = 0;
      origin_q[i] = 0;
    end
    rebuild_rotation();
    phase_cfg[1] = '{32'hffff8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    phase_cfg[2] = '{32'h0, 32'h00008000, 32'hffff8000, 32'h7fffffff, 32'h80000000, 32'h0};
    phase_cfg[3] = '{32'h00007fff, 32'h00004000, 32'hffffc000, 32'h1, 32'hffffffff,
                     32'h00010000};
    for (int ph = 4; ph < 8; ph++)
      for (int r = 0; r < 6; r++)
        phase_cfg[ph][r] = (r >= 3 && ph < 6) ? $urandom_range(0, 33554431) - 16777216
                                              : $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_tab[k]) begin
      send_point(directed_tab[k].pt, pick_gap(1'b0));
      if (directed_tab[k].typed) begin
        want = transform_point(directed_tab[k].pt);
        if (want !== directed_tab[k].res) begin
          $display("%0t: directed row %0d expected %h, predictor %h", $time, k,
                   directed_tab[k].res, want);
          errors++;
        end
      end
    end

    for (int ph = 1; ph < 8; ph++) begin
      wait_drained();
      for (int r = 0; r < 6; r++) apb_write(r[2:0], phase_cfg[ph][r]);
      rx_quiet = (ph == 3);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        p.op = $urandom_range(0, 1);
        p.x = pick_coord();
        p.y = pick_coord();
        p.z = pick_coord();
        if (ph == 2 && n == 20) hold_req = 1'b1;
        send_point(p, pick_gap(ph == 3));
      end
    end

    wait_drained();
    $display("Sent %0d point words and checked %0d results (%0d saturated) over 8 frame",
             words_in, words_out, sat_seen);
    $display("settings, including angles of -pi and extreme origins.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ertp_pkg.sv
rtl/core/ertp_in_if.sv
rtl/core/ertp_out_if.sv
rtl/core/euler_rigid_point_transform_top.sv
dv/testbench.sv
